// File: src/stack_push_pop_sequencer_defines.svh
// assertion macros shared by the sequencer modules
`ifndef STACK_PUSH_POP_SEQUENCER_DEFINES_SVH
`define STACK_PUSH_POP_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define SPPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define SPPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPPS_ASSERT_IMP(label, ante, cons, msg)
`define SPPS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: src/spps_pkg.sv
// types and constants of the stack push/pop sequencer
package spps_pkg;

  localparam int LIST_BITS = 8;
  localparam int SEL_BITS  = LIST_BITS + 1;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 4;
  localparam int ADDR_W    = 32;

  localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;
  localparam logic [IDX_W-1:0]  REG_LINK   = 4'd14;
  localparam logic [IDX_W-1:0]  REG_PC     = 4'd15;

  typedef struct packed {
    logic                 mode;
    logic [LIST_BITS-1:0] register_list;
    logic                 link_or_pc;
    logic [ADDR_W-1:0]    stack_pointer;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [IDX_W-1:0]  register_index;
    logic              is_write;
    logic              transfer_valid;
    logic [ADDR_W-1:0] new_stack_pointer;
    logic              last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

// File: src/stack_push_pop_sequencer.sv
// top level of the stack push/pop sequencer
`include "stack_push_pop_sequencer_defines.svh"

// Breaks one stack push or pop request into single word transfers, one per
// selected register in increasing register order (register 14 joins a push
// and register 15 a pop when link_or_pc is set). A push stores upward from
// sp - 4*count and leaves that as the new stack pointer; a pop loads upward
// from sp and leaves sp + 4*count. An empty selection gives one result with
// transfer_valid low and last high. One request is handled at a time: a
// load step, then one result per cycle from the single address counter and
// lowest-bit picker while the result side does not stall; a request gives
// n results (1 to 9). The result register lets a new request be taken
// while the final result still waits to be accepted.
module stack_push_pop_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  spps_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output spps_pkg::rsp_t   rsp
);
  import spps_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // state machine: idle / run, owns both handshakes
  spps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // mask, address counter and result register
  spps_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

  // an empty request reports a single closing result at the old sp
  `SPPS_ASSERT_IMP(a_empty_is_last, rsp_valid && !rsp.transfer_valid, rsp.last && (rsp.word_address == rsp.new_stack_pointer), "empty result malformed")

endmodule

// File: src/spps_ctrl.sv
// control state machine and output valid of the sequencer
`include "stack_push_pop_sequencer_defines.svh"

module spps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output spps_pkg::dp_cmd_t cmd,
  input  spps_pkg::dp_sts_t sts
);
  import spps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.step       = 1'b0;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd.step       = 1'b1;
          rsp_valid_next = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `SPPS_ASSERT_NXT(a_load_enters_run, req_valid && !req_stall, state == ST_RUN, "accepted request did not start a run")
  `SPPS_ASSERT_IMP(a_no_step_when_full, cmd.step, !(rsp_valid && rsp_stall), "step overwrote a waiting result")
  `SPPS_ASSERT_NXT(a_step_shows_result, cmd.step, rsp_valid, "step did not present a result")

endmodule

// File: src/spps_dp.sv
// datapath: register mask, address counter and result register
`include "stack_push_pop_sequencer_defines.svh"

module spps_dp (
  input  logic              clk,
  input  logic              rst,
  input  spps_pkg::req_t    req,
  input  spps_pkg::dp_cmd_t cmd,
  output spps_pkg::dp_sts_t sts,
  output spps_pkg::rsp_t    rsp
);
  import spps_pkg::*;

  logic [SEL_BITS-1:0] mask;
  logic                pop;
  logic [ADDR_W-1:0]   addr;
  logic [ADDR_W-1:0]   nsp;

  logic [SEL_BITS-1:0] req_mask;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   span;
  logic [SEL_BITS-1:0] low_onehot;
  logic [SEL_BITS-1:0] rest;
  logic [IDX_W-1:0]    idx_low;
  logic                empty;
  rsp_t                rsp_next;

  // count of selected registers at load
  assign req_mask = {req.link_or_pc, req.register_list};
  always_comb begin
    count = '0;
    for (int i = 0; i < SEL_BITS; i++) begin
      count = count + CNT_W'(req_mask[i]);
    end
  end
  assign span = {{(ADDR_W-CNT_W-2){1'b0}}, count, 2'b00};

  // lowest selected register
  assign low_onehot = mask & (~mask + SEL_BITS'(1));
  assign rest       = mask & ~low_onehot;
  assign empty      = (mask == '0);
  assign sts.last   = (rest == '0);

  always_comb begin
    idx_low = '0;
    for (int i = 0; i < SEL_BITS; i++) begin
      if (low_onehot[i]) begin
        idx_low = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rsp_next.word_address      = addr;
    rsp_next.is_write          = !pop && !empty;
    rsp_next.transfer_valid    = !empty;
    rsp_next.new_stack_pointer = nsp;
    rsp_next.last              = sts.last;
    if (idx_low == IDX_W'(LIST_BITS)) begin
      rsp_next.register_index = pop ? REG_PC : REG_LINK;
    end else begin
      rsp_next.register_index = idx_low;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask <= req_mask;
      pop  <= req.mode;
      addr <= req.mode ? req.stack_pointer : req.stack_pointer - span;
      nsp  <= req.mode ? req.stack_pointer + span : req.stack_pointer - span;
    end else if (cmd.step) begin
      mask <= rest;
      addr <= addr + WORD_BYTES;
      rsp  <= rsp_next;
    end
  end

  `SPPS_ASSERT_NXT(a_more_after_nonlast, cmd.step && !sts.last, mask != '0, "mask ran dry before last")

endmodule
